### rtl/ibmh_pkg.sv
// Package with shared constants and types of the heap core.
`timescale 1ns / 1ps
package ibmh_pkg;
    localparam int MaxEntriesDefault = 256;
    localparam int IdCountDefault    = 256;
    localparam int KeyBitsDefault    = 32;
    localparam int CapBits           = 9;
    localparam logic [CapBits-1:0] CapReset = 9'd256;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SETKEY = 2'd1,
        OP_DELMIN = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;
endpackage

### rtl/ibmh_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
`timescale 1ns / 1ps
module ibmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/indexed_binary_min_heap_core.sv
// Top level of the indexed binary min-heap priority queue.
`timescale 1ns / 1ps
// Usage: each request word on s_ (opcode, item_id, key_in, payload_in) gives one
// result word on m_ (status, id_out, key_out, payload_out). Opcodes: insert,
// set key, delete minimum, remove by id. The heap lives in one memory of
// entries {key, id, payload} indexed by slot, and the id-to-slot map lives in
// a second memory.
// Each sift step is one read of the heap memory (two for the children) and one
// write, so the memory port sets the rate.
// One request is worked on at a time; s_ready is high only when idle.
// Reset: after aresetn the position map is cleared by a pass over all ID_COUNT
// entries, one entry a cycle, during which no request is taken. Configuration
// writes on cfg_ (capacity_limit) are taken at any time.
// Stall: a result waits in the output register until m_ready; the next
// request is taken only after the result was delivered.
module indexed_binary_min_heap_core
    import ibmh_pkg::*;
#(
    parameter int MAX_ENTRIES = MaxEntriesDefault,
    parameter int ID_COUNT    = IdCountDefault,
    parameter int KEY_BITS    = KeyBitsDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CapBits-1:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [7:0]         s_item_id,
    input  logic signed [31:0] s_key_in,
    input  logic [31:0]        s_payload_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [7:0]         m_id_out,
    output logic signed [31:0] m_key_out,
    output logic [31:0]        m_payload_out
);
    localparam int SB = $clog2(MAX_ENTRIES + 1);
    localparam int IB = $clog2(ID_COUNT);
    localparam int EW = KEY_BITS + IB + 32;
    localparam int LB = $clog2(MAX_ENTRIES + 1) + 1;

    typedef enum logic [11:0] {
        S_CLR   = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_LOOK  = 12'b000000000100,
        S_DEC   = 12'b000000001000,
        S_LAST  = 12'b000000010000,
        S_PLACE = 12'b000000100000,
        S_UPRD  = 12'b000001000000,
        S_UPCMP = 12'b000010000000,
        S_DNL   = 12'b000100000000,
        S_DNR   = 12'b001000000000,
        S_DNCMP = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg;
    logic [CapBits-1:0] cap_reg;
    logic [SB-1:0] count_reg;
    logic [1:0] op_reg;
    logic [7:0] id_in_reg;
    logic signed [KEY_BITS-1:0] key_reg, old_reg;
    logic [31:0] pay_reg;
    logic [IB-1:0] ent_id_reg, clr_reg;
    logic [SB-1:0] p_reg, slot_reg;
    logic [EW-1:0] lc_reg;
    logic [2:0] st_reg;
    logic [7:0] oid_reg;
    logic [31:0] okey_reg, opay_reg;
    logic [SB-1:0] lim;

    logic hp_we; logic [SB-1:0] hp_wa, hp_ra; logic [EW-1:0] hp_wd, hp_rd;
    logic pm_we; logic [IB-1:0] pm_wa, pm_ra; logic [SB-1:0] pm_wd, pm_rd;

    ibmh_ram #(.WIDTH(EW), .DEPTH(2 ** SB)) u_heap (
        .aclk(aclk), .we(hp_we), .waddr(hp_wa), .wdata(hp_wd), .raddr(hp_ra), .rdata(hp_rd));
    ibmh_ram #(.WIDTH(SB), .DEPTH(2 ** IB)) u_pmap (
        .aclk(aclk), .we(pm_we), .waddr(pm_wa), .wdata(pm_wd), .raddr(pm_ra), .rdata(pm_rd));

    logic signed [KEY_BITS-1:0] rd_key, lc_key;
    logic [IB-1:0] rd_id;
    logic [31:0] rd_pay;
    logic id_ok;
    logic [LB-1:0] cpos;
    assign rd_key = hp_rd[EW-1 -: KEY_BITS];
    assign rd_id  = hp_rd[32 +: IB];
    assign rd_pay = hp_rd[31:0];
    assign lc_key = lc_reg[EW-1 -: KEY_BITS];
    assign id_ok  = ({24'd0, id_in_reg} < 32'(ID_COUNT));
    assign cpos   = {p_reg, 1'b0};
    assign lim    = (32'(cap_reg) > 32'(MAX_ENTRIES)) ? SB'(MAX_ENTRIES) : SB'(cap_reg);

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign m_status  = st_reg;
    assign m_id_out  = oid_reg;
    assign m_key_out = okey_reg;
    assign m_payload_out = opay_reg;

    always_comb begin
        hp_we = 1'b0; hp_wa = p_reg; hp_wd = {key_reg, ent_id_reg, pay_reg}; hp_ra = p_reg;
        pm_we = 1'b0; pm_wa = ent_id_reg; pm_wd = p_reg; pm_ra = id_in_reg[IB-1:0];
        unique case (state_reg)
            S_CLR: begin
                pm_we = 1'b1; pm_wa = clr_reg; pm_wd = '0;
            end
            S_IDLE: pm_ra = s_item_id[IB-1:0];
            S_LOOK: hp_ra = (op_t'(op_reg) == OP_DELMIN) ? SB'(1) : pm_rd;
            S_DEC: if (op_t'(op_reg) != OP_SETKEY) begin
                pm_we = 1'b1; pm_wa = rd_id; pm_wd = '0;
            end
            S_LAST: hp_ra = count_reg + SB'(1);
            S_PLACE: begin
                hp_we = 1'b1; pm_we = 1'b1;
                if (op_t'(op_reg) != OP_SETKEY) begin
                    hp_wd = hp_rd; pm_wa = rd_id;
                end
            end
            S_UPRD: hp_ra = p_reg >> 1;
            S_UPCMP: if (p_reg > SB'(1) && key_reg < rd_key) begin
                hp_we = 1'b1; hp_wd = hp_rd; pm_we = 1'b1; pm_wa = rd_id;
            end
            S_DNL: hp_ra = cpos[SB-1:0];
            S_DNR: hp_ra = cpos[SB-1:0] + SB'(1);
            S_DNCMP: begin
                if (LB'(cpos) + LB'(1) <= LB'(count_reg) && rd_key < lc_key) begin
                    if (rd_key < key_reg) begin
                        hp_we = 1'b1; hp_wd = hp_rd; pm_we = 1'b1; pm_wa = rd_id;
                    end
                end else if (lc_key < key_reg) begin
                    hp_we = 1'b1; hp_wd = lc_reg; pm_we = 1'b1; pm_wa = lc_reg[32 +: IB];
                end
            end
            default: ;
        endcase
        if ((state_reg == S_UPCMP && !(p_reg > SB'(1) && key_reg < rd_key)) ||
            (state_reg == S_DNCMP && !hp_we)) begin
            hp_we = 1'b1; pm_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR; clr_reg <= '0; count_reg <= '0; cap_reg <= CapReset;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            unique case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + IB'(1);
                    if (32'(clr_reg) == ID_COUNT - 1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: if (s_valid) begin
                    op_reg <= s_opcode; id_in_reg <= s_item_id;
                    key_reg <= KEY_BITS'(64'(s_key_in)); pay_reg <= s_payload_in;
                    state_reg <= S_LOOK;
                end
                S_LOOK: begin
                    oid_reg <= '0; okey_reg <= '0; opay_reg <= '0;
                    unique case (op_t'(op_reg))
                        OP_INSERT: begin
                            if (count_reg >= lim) begin
                                st_reg <= ST_FULL; state_reg <= S_OUT;
                            end else if (!id_ok) begin
                                st_reg <= ST_NOTFOUND; state_reg <= S_OUT;
                            end else if (pm_rd != '0) begin
                                st_reg <= ST_DUP; state_reg <= S_OUT;
                            end else begin
                                st_reg <= ST_OK;
                                count_reg <= count_reg + SB'(1);
                                p_reg <= count_reg + SB'(1);
                                ent_id_reg <= id_in_reg[IB-1:0];
                                state_reg <= S_UPRD;
                            end
                        end
                        OP_DELMIN: begin
                            if (count_reg == '0) begin
                                st_reg <= ST_EMPTY; state_reg <= S_OUT;
                            end else begin
                                st_reg <= ST_OK;
                                p_reg <= SB'(1); slot_reg <= SB'(1); state_reg <= S_DEC;
                            end
                        end
                        default: begin
                            if (!id_ok || pm_rd == '0) begin
                                st_reg <= ST_NOTFOUND; state_reg <= S_OUT;
                            end else begin
                                st_reg <= ST_OK;
                                p_reg <= pm_rd; slot_reg <= pm_rd; state_reg <= S_DEC;
                            end
                        end
                    endcase
                end
                S_DEC: begin
                    // The addressed slot's entry is now on the read port.
                    old_reg <= rd_key;
                    if (op_t'(op_reg) == OP_SETKEY) begin
                        ent_id_reg <= rd_id; pay_reg <= rd_pay;
                        state_reg <= (key_reg < rd_key) ? S_UPRD
                                   : (key_reg > rd_key) ? S_DNL : S_PLACE;
                    end else begin
                        ent_id_reg <= rd_id;
                        if (op_t'(op_reg) == OP_DELMIN) oid_reg <= 8'(rd_id);
                        okey_reg <= 32'(64'(rd_key)); opay_reg <= rd_pay;
                        count_reg <= count_reg - SB'(1);
                        state_reg <= (slot_reg == count_reg) ? S_OUT : S_LAST;
                    end
                end
                S_LAST: state_reg <= S_PLACE;
                S_PLACE: begin
                    if (op_t'(op_reg) == OP_SETKEY) begin
                        state_reg <= S_OUT;
                    end else begin
                        // The last entry now sits in the freed slot; sift it from there.
                        key_reg <= rd_key; ent_id_reg <= rd_id; pay_reg <= rd_pay;
                        p_reg <= slot_reg;
                        state_reg <= (rd_key < old_reg) ? S_UPRD
                                   : (rd_key > old_reg) ? S_DNL : S_OUT;
                    end
                end
                S_UPRD: state_reg <= S_UPCMP;
                S_UPCMP: begin
                    if (p_reg > SB'(1) && key_reg < rd_key) begin
                        p_reg <= p_reg >> 1; state_reg <= S_UPRD;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_DNL: begin
                    if (LB'(cpos) > LB'(count_reg)) begin
                        state_reg <= S_DNCMP; lc_reg <= {key_reg, ent_id_reg, pay_reg};
                    end else begin
                        state_reg <= S_DNR;
                    end
                end
                S_DNR: begin
                    lc_reg <= hp_rd; state_reg <= S_DNCMP;
                end
                S_DNCMP: begin
                    if (LB'(cpos) > LB'(count_reg)) begin
                        state_reg <= S_OUT;
                    end else if (LB'(cpos) + LB'(1) <= LB'(count_reg) && rd_key < lc_key) begin
                        if (rd_key < key_reg) begin
                            p_reg <= cpos[SB-1:0] + SB'(1); state_reg <= S_DNL;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end else if (lc_key < key_reg) begin
                        p_reg <= cpos[SB-1:0]; state_reg <= S_DNL;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: if (m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    property p_ready_idle;
        @(posedge aclk) disable iff (!aresetn) s_ready |-> !m_valid;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("ready while result pending");
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= MAX_ENTRIES) else $error("count overflow");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)) else $error("result lost");
endmodule
